[rtl/redmean_contrast_nudge_unit_assert.svh]
// Assertion macros for the redmean contrast nudge unit.
// Included by the top level only; depends on nothing else.

`ifndef REDMEAN_CONTRAST_NUDGE_UNIT_ASSERT_SVH
`define REDMEAN_CONTRAST_NUDGE_UNIT_ASSERT_SVH

// Condition and consequence in the same clock cycle.
`define RCN_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("redmean_contrast_nudge_unit: same-cycle check failed");

// Condition in one cycle, consequence in the next.
`define RCN_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("redmean_contrast_nudge_unit: next-cycle check failed");

`endif

[rtl/rcn_pkg.sv]
// Shared types and constants of the redmean contrast nudge unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rcn_pkg;

    // Colour packing: red in the low byte, then green, then blue.
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int COLOR_W = CH_W * NUM_CH;

    // Threshold register and weighted distance widths.
    localparam int THR_W  = 28;
    localparam int DIST_W = 28;
    localparam logic [THR_W-1:0] THR_RESET = 28'd584970;

    // Any non-zero weighted distance is at least 2^9, since every weight is 512 or more.
    localparam int MIN_DIST_LOG2 = 9;

    // Redmean weights: red 512+m, green 4*256, blue 767-m.
    localparam int WEIGHT_W = 10;
    localparam int SQ_W     = 2 * CH_W;
    localparam logic [WEIGHT_W-1:0] W_R_BASE = 10'd512;
    localparam logic [WEIGHT_W-1:0] W_B_BASE = 10'd767;
    localparam int W_G_SHIFT = 10;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Side information that travels with an item down the pipeline.
    typedef struct packed {
        logic               nudge;
        logic [COLOR_W-1:0] base;
        logic [COLOR_W-1:0] text;
    } side_t;

    // One finished result.
    typedef struct packed {
        logic               nudged;
        logic [COLOR_W-1:0] color;
    } result_t;

endpackage

[rtl/rcn_dist.sv]
// Redmean weighted squared distance, two register stages.
// Depends on rcn_pkg.
`timescale 1ns / 1ps

module rcn_dist
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rcn_pkg::COLOR_W-1:0] base_color,
    input  logic [rcn_pkg::COLOR_W-1:0] text_color,
    output logic                        out_valid,
    output rcn_pkg::side_t              out_side,
    output logic [rcn_pkg::DIST_W-1:0]  dist_sq
);

    localparam int PROD_W = rcn_pkg::WEIGHT_W + rcn_pkg::SQ_W;

    logic [rcn_pkg::SQ_W-1:0] sq_next [rcn_pkg::NUM_CH];
    logic [rcn_pkg::CH_W:0]   red_sum;
    logic [rcn_pkg::CH_W-1:0] m_next;

    logic                     a_valid_reg;
    rcn_pkg::side_t           a_side_reg;
    logic [rcn_pkg::CH_W-1:0] a_m_reg;
    logic [rcn_pkg::SQ_W-1:0] a_sq_reg [rcn_pkg::NUM_CH];

    logic [rcn_pkg::WEIGHT_W-1:0] w_r;
    logic [rcn_pkg::WEIGHT_W-1:0] w_b;
    logic [PROD_W-1:0]            prod_r;
    logic [PROD_W-1:0]            prod_b;
    logic [rcn_pkg::DIST_W-1:0]   dist_next;

    logic                       b_valid_reg;
    rcn_pkg::side_t             b_side_reg;
    logic [rcn_pkg::DIST_W-1:0] b_dist_reg;

    // Stage A: absolute channel differences and their squares.
    for (genvar c = 0; c < rcn_pkg::NUM_CH; c++) begin : g_ch
        logic [rcn_pkg::CH_W-1:0] base_ch;
        logic [rcn_pkg::CH_W-1:0] text_ch;
        logic [rcn_pkg::CH_W-1:0] mag;

        assign base_ch = base_color[c*rcn_pkg::CH_W +: rcn_pkg::CH_W];
        assign text_ch = text_color[c*rcn_pkg::CH_W +: rcn_pkg::CH_W];
        assign mag     = (text_ch >= base_ch) ? (text_ch - base_ch) : (base_ch - text_ch);
        assign sq_next[c] = rcn_pkg::SQ_W'(mag) * rcn_pkg::SQ_W'(mag);
    end

    // The mean red level selects the red and blue weights.
    assign red_sum = {1'b0, base_color[rcn_pkg::CH_W-1:0]}
                   + {1'b0, text_color[rcn_pkg::CH_W-1:0]};
    assign m_next  = red_sum[rcn_pkg::CH_W:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= '{nudge: 1'b0, base: base_color, text: text_color};
            a_m_reg    <= m_next;
            for (int c = 0; c < rcn_pkg::NUM_CH; c++)
            begin
                a_sq_reg[c] <= sq_next[c];
            end
        end
    end

    // Stage B: weight the squares and sum them.
    assign w_r    = rcn_pkg::W_R_BASE + rcn_pkg::WEIGHT_W'(a_m_reg);
    assign w_b    = rcn_pkg::W_B_BASE - rcn_pkg::WEIGHT_W'(a_m_reg);
    assign prod_r = PROD_W'(w_r) * PROD_W'(a_sq_reg[0]);
    assign prod_b = PROD_W'(w_b) * PROD_W'(a_sq_reg[2]);
    assign dist_next = rcn_pkg::DIST_W'(prod_r)
                     + (rcn_pkg::DIST_W'(a_sq_reg[1]) << rcn_pkg::W_G_SHIFT)
                     + rcn_pkg::DIST_W'(prod_b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_side_reg <= a_side_reg;
            b_dist_reg <= dist_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_side  = b_side_reg;
    assign dist_sq   = b_dist_reg;

endmodule

[rtl/rcn_div.sv]
// Pipelined restoring divider: floor(threshold * 2^(2F) / distance), one quotient
// bit per stage, plus the entry stage that decides whether an item is nudged.
// Depends on rcn_pkg.
`timescale 1ns / 1ps

module rcn_div
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  rcn_pkg::side_t             in_side,
    input  logic [rcn_pkg::DIST_W-1:0] dist_sq,
    input  logic [rcn_pkg::THR_W-1:0]  thr,
    output logic                       out_valid,
    output rcn_pkg::side_t             out_side,
    output logic [(rcn_pkg::THR_W - rcn_pkg::MIN_DIST_LOG2 + 2*FRAC_BITS)-1:0] quot
);

    // The top bits of the dividend go straight into the remainder; they stay below
    // any non-zero distance, so the quotient has QW bits.
    localparam int NUM_LO = rcn_pkg::THR_W - rcn_pkg::MIN_DIST_LOG2;
    localparam int QW     = NUM_LO + 2 * FRAC_BITS;

    logic                       valid_reg [0:QW];
    rcn_pkg::side_t             side_reg  [0:QW];
    logic [QW-1:0]              nq_reg    [0:QW];
    logic [rcn_pkg::DIST_W-1:0] rem_reg   [0:QW-1];
    logic [rcn_pkg::DIST_W-1:0] dist_reg  [0:QW-1];

    rcn_pkg::side_t side_next;

    // Entry stage: nudge decision and divider set-up.
    always_comb
    begin
        side_next       = in_side;
        side_next.nudge = (dist_sq != '0) && (dist_sq < thr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            dist_reg[0] <= dist_sq;
            rem_reg[0]  <= rcn_pkg::DIST_W'(thr[rcn_pkg::THR_W-1:NUM_LO]);
            nq_reg[0]   <= {thr[NUM_LO-1:0], {(2*FRAC_BITS){1'b0}}};
        end
    end

    // Division steps: the dividend shifts out at the top while quotient bits shift in.
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [rcn_pkg::DIST_W:0] trial;
        logic                     ge;

        assign trial = {rem_reg[k], nq_reg[k][QW-1]};
        assign ge    = trial >= {1'b0, dist_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
                nq_reg[k+1]   <= {nq_reg[k][QW-2:0], ge};
            end
        end

        // The remainder and divisor are not needed after the last step.
        if (k < QW - 1) begin : g_carry
            logic [rcn_pkg::DIST_W:0]   diff;
            logic [rcn_pkg::DIST_W-1:0] rem_next;

            assign diff     = trial - {1'b0, dist_reg[k]};
            assign rem_next = ge ? diff[rcn_pkg::DIST_W-1:0] : trial[rcn_pkg::DIST_W-1:0];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1]  <= rem_next;
                    dist_reg[k+1] <= dist_reg[k];
                end
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign out_side  = side_reg[QW];
    assign quot      = nq_reg[QW];

endmodule

[rtl/rcn_sqrt.sv]
// Pipelined restoring integer square root of the quotient, one root bit per stage.
// The root is the scale factor with FRAC_BITS fraction bits. Depends on rcn_pkg.
`timescale 1ns / 1ps

module rcn_sqrt
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  rcn_pkg::side_t in_side,
    input  logic [(rcn_pkg::THR_W - rcn_pkg::MIN_DIST_LOG2 + 2*FRAC_BITS)-1:0] quot,
    output logic           out_valid,
    output rcn_pkg::side_t out_side,
    output logic [(rcn_pkg::THR_W - rcn_pkg::MIN_DIST_LOG2 + 2*FRAC_BITS + 1)/2-1:0] scale
);

    localparam int QW = rcn_pkg::THR_W - rcn_pkg::MIN_DIST_LOG2 + 2 * FRAC_BITS;
    localparam int SW = (QW + 1) / 2;
    localparam int QP = 2 * SW;
    // The remainder never exceeds twice the partial root.
    localparam int RW = SW + 2;

    logic           valid_reg [1:SW];
    rcn_pkg::side_t side_reg  [1:SW];
    logic [SW-1:0]  root_reg  [1:SW];
    logic [RW-1:0]  rem_reg   [1:SW-1];
    logic [QP-1:0]  qs_reg    [1:SW-1];

    for (genvar j = 0; j < SW; j++) begin : g_step
        logic           valid_in;
        rcn_pkg::side_t side_in;
        logic [SW-1:0]  root_in;
        logic [RW-1:0]  rem_in;
        logic [QP-1:0]  qs_in;
        logic [RW-1:0]  t;
        logic [RW-1:0]  trial;
        logic           ge;

        // The first step starts from a cleared remainder and root.
        if (j == 0) begin : g_first
            assign valid_in = in_valid;
            assign side_in  = in_side;
            assign root_in  = '0;
            assign rem_in   = '0;
            assign qs_in    = QP'(quot);
        end
        else begin : g_next
            assign valid_in = valid_reg[j];
            assign side_in  = side_reg[j];
            assign root_in  = root_reg[j];
            assign rem_in   = rem_reg[j];
            assign qs_in    = qs_reg[j];
        end

        // Bring down the next pair of radicand bits and try root bit one.
        assign t     = {rem_in[RW-3:0], qs_in[QP-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j+1] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j+1] <= side_in;
                root_reg[j+1] <= {root_in[SW-2:0], ge};
            end
        end

        // Remainder and radicand are not needed after the last step.
        if (j < SW - 1) begin : g_carry
            logic [RW-1:0] rem_next;
            logic [QP-1:0] qs_next;

            assign rem_next = ge ? (t - trial) : t;
            assign qs_next  = {qs_in[QP-3:0], 2'b00};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= rem_next;
                    qs_reg[j+1]  <= qs_next;
                end
            end
        end
    end

    assign out_valid = valid_reg[SW];
    assign out_side  = side_reg[SW];
    assign scale     = root_reg[SW];

endmodule

[rtl/rcn_push.sv]
// Scales each channel difference, rounds, adds it to the reference and clamps.
// Two register stages: multiply, then round and clamp. Depends on rcn_pkg.
`timescale 1ns / 1ps

module rcn_push
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  rcn_pkg::side_t   in_side,
    input  logic [(rcn_pkg::THR_W - rcn_pkg::MIN_DIST_LOG2 + 2*FRAC_BITS + 1)/2-1:0] scale,
    output logic             out_valid,
    output rcn_pkg::result_t out_result
);

    localparam int QW   = rcn_pkg::THR_W - rcn_pkg::MIN_DIST_LOG2 + 2 * FRAC_BITS;
    localparam int SW   = (QW + 1) / 2;
    localparam int PW   = rcn_pkg::CH_W + SW;
    // Scaled difference after rounding, including the rounding carry.
    localparam int SC_W = PW + 1 - FRAC_BITS;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC_BITS - 1);

    logic [PW-1:0] prod_next [rcn_pkg::NUM_CH];
    logic          neg_next  [rcn_pkg::NUM_CH];

    logic           p_valid_reg;
    rcn_pkg::side_t p_side_reg;
    logic [PW-1:0]  p_prod_reg [rcn_pkg::NUM_CH];
    logic           p_neg_reg  [rcn_pkg::NUM_CH];

    logic [rcn_pkg::COLOR_W-1:0] pushed;
    rcn_pkg::result_t            result_next;

    logic             r_valid_reg;
    rcn_pkg::result_t r_result_reg;

    // Stage 1: signed channel differences and the product with the scale.
    for (genvar c = 0; c < rcn_pkg::NUM_CH; c++) begin : g_mul
        logic [rcn_pkg::CH_W-1:0] base_ch;
        logic [rcn_pkg::CH_W-1:0] text_ch;
        logic [rcn_pkg::CH_W-1:0] mag;

        assign base_ch      = in_side.base[c*rcn_pkg::CH_W +: rcn_pkg::CH_W];
        assign text_ch      = in_side.text[c*rcn_pkg::CH_W +: rcn_pkg::CH_W];
        assign neg_next[c]  = text_ch < base_ch;
        assign mag          = neg_next[c] ? (base_ch - text_ch) : (text_ch - base_ch);
        assign prod_next[c] = PW'(mag) * PW'(scale);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= in_valid;
            r_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_side_reg <= in_side;
            for (int c = 0; c < rcn_pkg::NUM_CH; c++)
            begin
                p_prod_reg[c] <= prod_next[c];
                p_neg_reg[c]  <= neg_next[c];
            end
        end
    end

    // Stage 2: round half away from zero, apply the sign and saturate to the channel range.
    for (genvar c = 0; c < rcn_pkg::NUM_CH; c++) begin : g_clamp
        logic [rcn_pkg::CH_W-1:0] base_ch;
        logic [PW:0]              rounded;
        logic [SC_W-1:0]          scaled;
        logic [SC_W-1:0]          base_ext;
        logic [SC_W:0]            up_sum;
        logic [SC_W-1:0]          down_diff;

        assign base_ch   = p_side_reg.base[c*rcn_pkg::CH_W +: rcn_pkg::CH_W];
        assign rounded   = {1'b0, p_prod_reg[c]} + HALF;
        assign scaled    = rounded[PW:FRAC_BITS];
        assign base_ext  = SC_W'(base_ch);
        assign up_sum    = {1'b0, scaled} + {1'b0, base_ext};
        assign down_diff = base_ext - scaled;

        always_comb
        begin
            if (p_neg_reg[c])
            begin
                if (scaled > base_ext)
                begin
                    pushed[c*rcn_pkg::CH_W +: rcn_pkg::CH_W] = '0;
                end
                else
                begin
                    pushed[c*rcn_pkg::CH_W +: rcn_pkg::CH_W] = down_diff[rcn_pkg::CH_W-1:0];
                end
            end
            else
            begin
                if (up_sum > (SC_W+1)'(rcn_pkg::CH_MAX))
                begin
                    pushed[c*rcn_pkg::CH_W +: rcn_pkg::CH_W] = rcn_pkg::CH_MAX;
                end
                else
                begin
                    pushed[c*rcn_pkg::CH_W +: rcn_pkg::CH_W] = up_sum[rcn_pkg::CH_W-1:0];
                end
            end
        end
    end

    // Items that are not nudged pass the target colour through.
    always_comb
    begin
        result_next.nudged = p_side_reg.nudge;
        result_next.color  = p_side_reg.nudge ? pushed : p_side_reg.text;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_result_reg <= result_next;
        end
    end

    assign out_valid  = r_valid_reg;
    assign out_result = r_result_reg;

endmodule

[rtl/redmean_contrast_nudge_unit.sv]
// Redmean contrast nudge unit. Takes one colour pair per clock cycle on the input stream
// while s_axis_tready is high and delivers one result per pair, in order. Path from input
// to output: the weighted distance (stages A and B), the nudge decision, the restoring
// divider (one quotient bit per stage), the square root (one root bit per stage),
// scaling and clamping (multiply, then round and clamp) and the output register. The
// sustained rate is one item per cycle while the output is taken; a skid register
// behind the output lets the pipeline and the input side keep moving while the output
// stalls, until a result meets the full output register. The threshold register must
// be written only while no item is in flight. Depends on rcn_pkg, all rcn_* modules
// and the assertion header.
`timescale 1ns / 1ps

`include "redmean_contrast_nudge_unit_assert.svh"

module redmean_contrast_nudge_unit
#(
    parameter int SCALE_FRAC_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Threshold register write port.
    input  logic                       cfg_we,
    input  logic [rcn_pkg::THR_W-1:0]  cfg_wdata,      // min_distance_sq
    // Input stream.
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [47:0]                s_axis_tdata,   // base_color [23:0], text_color [47:24]
    // Output stream.
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata,   // adjusted_color [23:0]
    output logic [0:0]                 m_axis_tuser    // was_nudged [0]
);

    localparam int QW = rcn_pkg::THR_W - rcn_pkg::MIN_DIST_LOG2 + 2 * SCALE_FRAC_BITS;
    localparam int SW = (QW + 1) / 2;

    logic [rcn_pkg::THR_W-1:0] thr_reg;
    logic                      en;

    logic                       dist_valid;
    rcn_pkg::side_t             dist_side;
    logic [rcn_pkg::DIST_W-1:0] dist_sq;

    logic           div_valid;
    rcn_pkg::side_t div_side;
    logic [QW-1:0]  quot;

    logic           sq_valid;
    rcn_pkg::side_t sq_side;
    logic [SW-1:0]  sq_scale;

    logic             pipe_valid;
    rcn_pkg::result_t pipe_result;

    logic             out_valid_reg;
    logic             out_valid_next;
    rcn_pkg::result_t out_result_reg;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    rcn_pkg::result_t skid_result_reg;
    logic             load_from_pipe;
    logic             load_from_skid;
    logic             load_skid;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= rcn_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // The whole pipeline moves while the skid register is empty.
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    rcn_dist u_dist
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_axis_tvalid),
        .base_color (s_axis_tdata[23:0]),
        .text_color (s_axis_tdata[47:24]),
        .out_valid  (dist_valid),
        .out_side   (dist_side),
        .dist_sq    (dist_sq)
    );

    rcn_div #(.FRAC_BITS(SCALE_FRAC_BITS)) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dist_valid),
        .in_side   (dist_side),
        .dist_sq   (dist_sq),
        .thr       (thr_reg),
        .out_valid (div_valid),
        .out_side  (div_side),
        .quot      (quot)
    );

    rcn_sqrt #(.FRAC_BITS(SCALE_FRAC_BITS)) u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_side   (div_side),
        .quot      (quot),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .scale     (sq_scale)
    );

    rcn_push #(.FRAC_BITS(SCALE_FRAC_BITS)) u_push
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (sq_valid),
        .in_side    (sq_side),
        .scale      (sq_scale),
        .out_valid  (pipe_valid),
        .out_result (pipe_result)
    );

    // Output register with a skid register behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_from_pipe  = 1'b0;
        load_from_skid  = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                load_from_skid  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (pipe_valid)
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                load_from_pipe = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_pipe)
        begin
            out_result_reg <= pipe_result;
        end
        else if (load_from_skid)
        begin
            out_result_reg <= skid_result_reg;
        end
        if (load_skid)
        begin
            skid_result_reg <= pipe_result;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_result_reg.color;
    assign m_axis_tuser[0] = out_result_reg.nudged;

    // A held item in the skid register always has one waiting in front of it.
    `RCN_ASSERT_NOW(a_skid_has_output, clk, rst_n, skid_valid_reg, out_valid_reg)

    // A taken output frees the skid register in the next cycle.
    `RCN_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_reg && m_axis_tready, !skid_valid_reg)

    // A nudged item has distance below the threshold, so its scale is at least one.
    `RCN_ASSERT_NOW(a_scale_at_least_one, clk, rst_n, sq_valid && sq_side.nudge, sq_scale[SW-1:SCALE_FRAC_BITS] != '0)

endmodule

[verif/redmean_contrast_nudge_unit_test.sv]
// Self-checking testbench for the redmean contrast nudge unit: directed table, then random pairs.
// Each result is compared against a typed-in result or a local predictor of the redmean nudge.
// Depends on rcn_pkg and the redmean_contrast_nudge_unit RTL.
`timescale 1ns / 1ps

module redmean_contrast_nudge_unit_test;

    localparam int FRAC_BITS   = 16;
    localparam int LATENCY     = 3 * FRAC_BITS + 35;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DIR_ROWS    = 20;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 165;

    localparam logic [rcn_pkg::THR_W-1:0] THR_MAX  = 28'hFFFFFFF;
    localparam logic [rcn_pkg::THR_W-1:0] THR_ZERO = 28'd0;
    localparam logic [rcn_pkg::THR_W-1:0] THR_ONE  = 28'd1;

    // Receiver stall patterns.
    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;

    // One row of the directed table. Where pin is set the result is typed in.
    typedef struct {
        logic                       set_thr;
        logic [rcn_pkg::THR_W-1:0]  thr;
        logic [23:0]                base;
        logic [23:0]                text;
        logic                       pin;
        logic [23:0]                want_color;
        logic                       want_nudged;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [rcn_pkg::THR_W-1:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    rcn_pkg::result_t          expected_colours[$];
    logic [rcn_pkg::THR_W-1:0] thr_shadow;
    int errors        = 0;
    int pairs_sent    = 0;
    int results_seen  = 0;
    int nudges_seen   = 0;
    int thr_writes    = 0;
    int cycle_count   = 0;
    int hold_requests = 0;

    // Directed pairs: extremes, identical colours, clamping and the threshold corner cases.
    dir_row_t dir_table [DIR_ROWS] = '{
        '{1'b0, 28'd0,     24'h000000, 24'h000000, 1'b1, 24'h000000, 1'b0},
        '{1'b0, 28'd0,     24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b0},
        '{1'b0, 28'd0,     24'h000000, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b0},
        '{1'b0, 28'd0,     24'h808080, 24'h808081, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 28'd0,     24'h808080, 24'h808180, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 28'd0,     24'h808080, 24'h818080, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 28'd0,     24'h101010, 24'h10100F, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 28'd0,     24'h000000, 24'h010101, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 28'd0,     24'hF8F8F8, 24'hFCFCFC, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 28'd0,     24'h080808, 24'h040404, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 28'd0,     24'hFF007F, 24'hFE017F, 1'b0, 24'h000000, 1'b0},
        '{1'b1, THR_ZERO,  24'h808080, 24'h818181, 1'b1, 24'h818181, 1'b0},
        '{1'b0, 28'd0,     24'h000000, 24'h000001, 1'b1, 24'h000001, 1'b0},
        '{1'b1, THR_ONE,   24'h123456, 24'h123457, 1'b1, 24'h123457, 1'b0},
        '{1'b1, THR_MAX,   24'h000000, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b1},
        '{1'b0, 28'd0,     24'hFFFFFF, 24'h000000, 1'b1, 24'h000000, 1'b1},
        '{1'b0, 28'd0,     24'h808080, 24'h808080, 1'b1, 24'h808080, 1'b0},
        '{1'b0, 28'd0,     24'h00FF00, 24'hFF00FF, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 28'd0,     24'h000000, 24'h000001, 1'b0, 24'h000000, 1'b0},
        '{1'b1, rcn_pkg::THR_RESET, 24'h3C5A78, 24'h3D5B79, 1'b0, 24'h000000, 1'b0}
    };

    redmean_contrast_nudge_unit #(
        .SCALE_FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    always #4 clk = ~clk;

    // Scale one channel delta, round half away from zero, add to the base level and clamp.
    function automatic logic [7:0] push_channel(input int base_level, input int delta,
                                                input logic [31:0] scale);
        longint mag;
        longint scaled;
        longint level;
        begin
            mag    = (delta < 0) ? -delta : delta;
            scaled = (mag * longint'(scale) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            level  = (delta < 0) ? base_level - scaled : base_level + scaled;
            if (level < 0)
                level = 0;
            if (level > 255)
                level = 255;
            return level[7:0];
        end
    endfunction

    // Expected result of one colour pair under the given threshold.
    function automatic rcn_pkg::result_t nudge_colour(input logic [23:0] base,
                                                      input logic [23:0] text,
                                                      input logic [rcn_pkg::THR_W-1:0] thr);
        int rb, gb, bb, rt, gt, bt, dr, dg, db, mean;
        longint wdist;
        logic [127:0] lhs, rhs, cand;
        logic [31:0] scale;
        rcn_pkg::result_t res;
        begin
            rb = int'(base[7:0]);
            gb = int'(base[15:8]);
            bb = int'(base[23:16]);
            rt = int'(text[7:0]);
            gt = int'(text[15:8]);
            bt = int'(text[23:16]);
            dr = rt - rb;
            dg = gt - gb;
            db = bt - bb;
            mean = (rb + rt) / 2;
            wdist = longint'(512 + mean) * dr * dr + longint'(1024) * dg * dg
                  + longint'(767 - mean) * db * db;
            if (wdist != 0 && wdist < longint'(thr)) begin
                // Exact root: the largest scale whose square times the distance stays within thr.
                scale = '0;
                rhs   = 128'(thr) << (2 * FRAC_BITS);
                for (int b = FRAC_BITS + 10; b >= 0; b--) begin
                    cand = 128'(scale | (32'd1 << b));
                    lhs  = cand * cand * 128'(wdist);
                    if (lhs <= rhs)
                        scale = cand[31:0];
                end
                res.color  = {push_channel(bb, db, scale), push_channel(gb, dg, scale),
                              push_channel(rb, dr, scale)};
                res.nudged = 1'b1;
            end
            else begin
                res.color  = text;
                res.nudged = 1'b0;
            end
            return res;
        end
    endfunction

    // Offer one pair and wait for it to be taken; the expectation is queued on acceptance.
    task automatic send_pair(input logic [23:0] base, input logic [23:0] text,
                             input logic pin, input rcn_pkg::result_t pinned);
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {text, base};
            do
                @(posedge clk);
            while (!s_axis_tready);
            if (pin)
                expected_colours.push_back(pinned);
            else
                expected_colours.push_back(nudge_colour(base, text, thr_shadow));
            pairs_sent++;
        end
    endtask

    // Sender gap of the given number of cycles.
    task automatic sender_gap(input int cycles);
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results;
        begin
            sender_gap(1);
            while (expected_colours.size() != 0)
                @(posedge clk);
        end
    endtask

    // Threshold write, only with the pipeline empty.
    task automatic write_threshold(input logic [rcn_pkg::THR_W-1:0] value);
        begin
            drain_results();
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= value;
            thr_shadow = value;
            @(negedge clk);
            cfg_we    <= 1'b0;
            thr_writes++;
        end
    endtask

    // Random pair: mostly a target close to the base, some identical, some unrelated.
    task automatic random_pair(output logic [23:0] base, output logic [23:0] text);
        int kind, spread, level;
        begin
            base = 24'($urandom);
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                spread = $urandom_range(1, $urandom_range(1, 48));
                for (int ch = 0; ch < 3; ch++) begin
                    level = int'(base[ch*8 +: 8]) + $urandom_range(0, 2 * spread) - spread;
                    if (level < 0)
                        level = 0;
                    if (level > 255)
                        level = 255;
                    text[ch*8 +: 8] = level[7:0];
                end
            end
            else if (kind == 6)
                text = base;
            else
                text = 24'($urandom);
        end
    endtask

    // Result checker.
    always @(posedge clk) begin : result_check
        rcn_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_colours.size() == 0) begin
                $error("unexpected result: adjusted_color %h, was_nudged %b",
                       m_axis_tdata, m_axis_tuser[0]);
                errors++;
            end
            else begin
                want = expected_colours.pop_front();
                if (m_axis_tdata !== want.color) begin
                    $error("adjusted_color: expected %h, actual %h", want.color, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[0] !== want.nudged) begin
                    $error("was_nudged: expected %b, actual %b", want.nudged, m_axis_tuser[0]);
                    errors++;
                end
                results_seen++;
                if (want.nudged)
                    nudges_seen++;
            end
        end
    end

    // Receiver: changing stall patterns, plus a long hold-off on request.
    always @(negedge clk) begin : receiver
        static ready_mode_t mode = READY_ALWAYS;
        static int mode_left = 0;
        static int hold_left = 0;
        static int hold_seen = 0;
        static int tick = 0;
        tick++;
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else begin
            if (mode_left == 0) begin
                mode      = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                READY_ALWAYS:   m_axis_tready <= 1'b1;
                READY_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                READY_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                READY_PERIODIC: m_axis_tready <= (tick % 5 != 0);
                default:        m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Main sequence.
    initial begin : stimulus
        logic [23:0] base, text;
        logic [rcn_pkg::THR_W-1:0] phase_thr [PHASES];
        rcn_pkg::result_t pinned;
        int burst, gap;
        thr_shadow = rcn_pkg::THR_RESET;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table.
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_table[i].set_thr)
                write_threshold(dir_table[i].thr);
            pinned.color  = dir_table[i].want_color;
            pinned.nudged = dir_table[i].want_nudged;
            send_pair(dir_table[i].base, dir_table[i].text, dir_table[i].pin, pinned);
        end

        // Random phases, each under its own threshold.
        phase_thr[0] = rcn_pkg::THR_RESET;
        phase_thr[1] = THR_MAX;
        phase_thr[2] = 28'($urandom_range(1, 268435455));
        phase_thr[3] = 28'($urandom_range(2000, 60000));
        phase_thr[4] = THR_ONE;
        phase_thr[5] = 28'($urandom_range(1000000, 20000000));
        phase_thr[6] = 28'($urandom_range(100000, 2000000));
        for (int p = 0; p < PHASES; p++) begin
            write_threshold(phase_thr[p]);
            // Every unequal pair is nudged here; hold the receiver off so the pipeline fills up.
            if (p == 1)
                hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; ) begin
                burst = $urandom_range(1, 30);
                for (int k = 0; k < burst && n < PHASE_ITEMS; k++, n++) begin
                    random_pair(base, text);
                    send_pair(base, text, 1'b0, pinned);
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                    sender_gap(gap);
            end
        end

        // Wind down.
        drain_results();
        repeat (LATENCY + 20) @(posedge clk);
        $display("Summary: %0d colour pairs sent under %0d threshold settings.",
                 pairs_sent, thr_writes + 1);
        $display("Summary: %0d results checked, %0d of them nudged, %0d mismatches.",
                 results_seen, nudges_seen, errors);
        if (errors == 0 && expected_colours.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/rcn_pkg.sv
rtl/rcn_dist.sv
rtl/rcn_div.sv
rtl/rcn_sqrt.sv
rtl/rcn_push.sv
rtl/redmean_contrast_nudge_unit.sv
verif/redmean_contrast_nudge_unit_test.sv
